// ===== sv/gdbd_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdbd_pkg
// Shared types, character codes and helpers for the remote serial protocol
// packet deframer.
// ----------------------------------------------------------------------------
package gdbd_pkg;

   // framing characters
   localparam logic [7:0] SOP_CHAR = 8'h24;   // '$'
   localparam logic [7:0] EOP_CHAR = 8'h23;   // '#'
   localparam logic [7:0] ESC_CHAR = 8'h7d;
   localparam logic [7:0] ESC_XOR  = 8'h20;

   // result kinds
   localparam logic [1:0] EV_DATA    = 2'd0;
   localparam logic [1:0] EV_GOOD    = 2'd1;
   localparam logic [1:0] EV_BAD     = 2'd2;
   localparam logic [1:0] EV_RESTART = 2'd3;

   // decoded digit with bit 4 flagging a non-hex character
   localparam logic [4:0] DIGIT_BAD = 5'h10;

   // event queue between front and back
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] kind;
      logic [7:0] data;
   } event_type;

   // Decode one hex character of either case.
   function automatic logic [4:0] hex_value(input logic [7:0] c);
      logic [4:0] v;
      v = DIGIT_BAD;
      if (c inside {[8'h30:8'h39]}) begin
         v = {1'b0, c[3:0]};
      end else if ((c inside {[8'h61:8'h66]}) || (c inside {[8'h41:8'h46]})) begin
         v = {1'b0, c[3:0] + 4'd9};
      end
      return v;
   endfunction

endpackage

// ===== sv/gdbd_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdbd_front
// Byte classifier: tracks framing, escapes and the running checksum, and
// turns each accepted byte into at most one event for the queue.
// ----------------------------------------------------------------------------
module gdbd_front
   import gdbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       ev_valid,
   output event_type  ev
);

   localparam logic [1:0] PH_HUNT = 2'd0;
   localparam logic [1:0] PH_BODY = 2'd1;
   localparam logic [1:0] PH_HI   = 2'd2;
   localparam logic [1:0] PH_LO   = 2'd3;

   logic [1:0] phase_ff, phase_in;
   logic       escape_ff, escape_in;
   logic [7:0] sum_ff, sum_in;
   logic [4:0] high_ff, high_in;
   logic       accept;
   logic [4:0] digit;
   logic       good;

   assign accept = req_valid && !req_stall;
   assign digit  = hex_value(req_rx_byte);
   assign good   = !high_ff[4] && !digit[4] && ({high_ff[3:0], digit[3:0]} == sum_ff);

   // classify the byte against the current phase
   always_comb begin
      phase_in  = phase_ff;
      escape_in = escape_ff;
      sum_in    = sum_ff;
      high_in   = high_ff;
      ev_valid  = 1'b0;
      ev.kind   = EV_DATA;
      ev.data   = 8'h00;
      if (accept) begin
         case (phase_ff)
            PH_HUNT: begin
               if (req_rx_byte == SOP_CHAR) begin
                  phase_in  = PH_BODY;
                  sum_in    = 8'h00;
                  escape_in = 1'b0;
               end
            end
            PH_BODY: begin
               if (escape_ff) begin
                  escape_in = 1'b0;
                  sum_in    = sum_ff + req_rx_byte;
                  ev_valid  = 1'b1;
                  ev.data   = req_rx_byte ^ ESC_XOR;
               end else if (req_rx_byte == SOP_CHAR) begin
                  sum_in   = 8'h00;
                  ev_valid = 1'b1;
                  ev.kind  = EV_RESTART;
               end else if (req_rx_byte == EOP_CHAR) begin
                  phase_in = PH_HI;
               end else begin
                  sum_in = sum_ff + req_rx_byte;
                  if (req_rx_byte == ESC_CHAR) begin
                     escape_in = 1'b1;
                  end else begin
                     ev_valid = 1'b1;
                     ev.data  = req_rx_byte;
                  end
               end
            end
            PH_HI: begin
               high_in  = digit;
               phase_in = PH_LO;
            end
            default: begin
               phase_in  = PH_HUNT;
               escape_in = 1'b0;
               ev_valid  = 1'b1;
               ev.kind   = good ? EV_GOOD : EV_BAD;
            end
         endcase
      end
   end

   // hold framing state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         escape_ff <= 1'b0;
         sum_ff    <= 8'h00;
         high_ff   <= 5'h00;
      end else begin
         phase_ff  <= phase_in;
         escape_ff <= escape_in;
         sum_ff    <= sum_in;
         high_ff   <= high_in;
      end
   end

   a_verdict_ends_packet: assert property (@(posedge clock) disable iff (reset)
      (accept && phase_ff == PH_LO) |=> (phase_ff == PH_HUNT && !escape_ff))
      else $error("verdict did not return to hunting");

   a_escape_in_body: assert property (@(posedge clock) disable iff (reset)
      escape_ff |-> (phase_ff == PH_BODY))
      else $error("escape pending outside the body");

endmodule

// ===== sv/gdbd_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdbd_queue
// Short event queue that lets the classifier run on while results wait.
// ----------------------------------------------------------------------------
module gdbd_queue
   import gdbd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  event_type push_ev,
   output logic      full,
   output logic      q_valid,
   output event_type q_ev,
   input  logic      pop
);

   event_type                mem [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]        count_ff, count_in;
   logic                     do_push;
   logic                     do_pop;

   assign full    = (count_ff == QUEUE_DEPTH[QUEUE_AW:0]);
   assign q_valid = (count_ff != '0);
   assign q_ev    = mem[rd_ptr_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && q_valid;

   // advance pointers and fill level
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // store the event beat
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem[wr_ptr_ff] <= push_ev;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("event pushed into a full queue");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QUEUE_DEPTH[QUEUE_AW:0])
      else $error("queue fill level out of range");

endmodule

// ===== sv/gdbd_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdbd_back
// Result stage: pulls events from the queue into the output register and
// formats the beat for the result channel.
// ----------------------------------------------------------------------------
module gdbd_back
   import gdbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       q_valid,
   input  event_type  q_ev,
   output logic       pop,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_payload_byte
);

   logic       valid_ff, valid_in;
   logic [1:0] kind_ff;
   logic [7:0] byte_ff;
   logic       load;

   assign load     = !valid_ff || !rsp_stall;
   assign pop      = q_valid && load;
   assign valid_in = load ? q_valid : valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // load the next beat, zero the byte for verdict and restart kinds
   always_ff @(posedge clock) begin
      if (pop) begin
         kind_ff <= q_ev.kind;
         byte_ff <= (q_ev.kind == EV_DATA) ? q_ev.data : 8'h00;
      end
   end

   assign rsp_valid        = valid_ff;
   assign rsp_event_kind   = kind_ff;
   assign rsp_payload_byte = byte_ff;

   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (valid_ff && kind_ff != EV_DATA) |-> (byte_ff == 8'h00))
      else $error("non-data beat carries a byte");

endmodule

// ===== sv/gdb_rsp_packet_deframer_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gdb_rsp_packet_deframer_core
// Remote serial protocol packet deframer: recovers '$' body '#' hh packets
// from a received byte stream.
// ----------------------------------------------------------------------------
// Takes one received byte per cycle on req_ and returns at most one beat per
// byte on rsp_: an unescaped payload byte, a good or bad checksum verdict,
// or a restart when an unescaped '$' appears inside a body. Bytes outside a
// packet, the opening '$', '#', the escape byte and the high checksum digit
// give no beat. A byte passes the classifier in the cycle it is accepted;
// its beat is queued before it reaches the output register. A two-entry
// event queue sits between the classifier and the output register, so input
// is stalled only once both queue entries are occupied behind a stalled
// output, and a byte is taken every cycle while results drain freely.
module gdb_rsp_packet_deframer_core
   import gdbd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_rx_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [1:0] rsp_event_kind,
   output logic [7:0] rsp_payload_byte
);

   logic      ev_valid;
   event_type ev;
   logic      q_full;
   logic      q_valid;
   event_type q_ev;
   logic      q_pop;

   assign req_stall = q_full;

   gdbd_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_rx_byte (req_rx_byte),
      .ev_valid    (ev_valid),
      .ev          (ev)
   );

   gdbd_queue u_queue (
      .clock   (clock),
      .reset   (reset),
      .push    (ev_valid),
      .push_ev (ev),
      .full    (q_full),
      .q_valid (q_valid),
      .q_ev    (q_ev),
      .pop     (q_pop)
   );

   gdbd_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_valid          (q_valid),
      .q_ev             (q_ev),
      .pop              (q_pop),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_event_kind   (rsp_event_kind),
      .rsp_payload_byte (rsp_payload_byte)
   );

endmodule
